[rtl/ipcsem_pkg.sv]
// shared types and constants for the inter-processor interrupt and semaphore block
// no dependencies
package ipcsem_pkg;

	localparam int NUM_CORES_DEF      = 4;
	localparam int NUM_LEVELS_DEF     = 32;
	localparam int NUM_SEMAPHORES_DEF = 32;

	localparam int DATA_W   = 32;
	localparam int CORE_W   = 2;
	localparam int SEM_W    = 5;
	localparam int LINE_W   = 4;
	localparam int S_TDATA_W = 40;
	localparam int S_TUSER_W = 4;
	localparam int M_TDATA_W = 40;

	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	typedef enum logic [2:0] {
		REG_RAW       = 3'd0,
		REG_MASK      = 3'd1,
		REG_STAT      = 3'd2,
		REG_CLEAR     = 3'd3,
		REG_SEM_MASK  = 3'd4,
		REG_SEM_STAT  = 3'd5,
		REG_SEM_CLEAR = 3'd6,
		REG_HANDSHAKE = 3'd7
	} reg_sel_t;

	typedef struct packed {
		logic              command;
		reg_sel_t          reg_select;
		logic [CORE_W-1:0] core_index;
		logic [SEM_W-1:0]  sem_index;
		logic [DATA_W-1:0] write_data;
	} req_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic [LINE_W-1:0] cpu_irq_lines;
		logic [LINE_W-1:0] sem_irq_lines;
		logic              access_error;
	} rsp_t;

endpackage

[rtl/ipcsem_bank.sv]
// register banks, semaphore owners and the access decode for one bus word
// depends on ipcsem_pkg
module ipcsem_bank #(
	parameter int NUM_CORES      = ipcsem_pkg::NUM_CORES_DEF,
	parameter int NUM_LEVELS     = ipcsem_pkg::NUM_LEVELS_DEF,
	parameter int NUM_SEMAPHORES = ipcsem_pkg::NUM_SEMAPHORES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  ipcsem_pkg::req_t  req,
	output ipcsem_pkg::rsp_t  rsp
);
	import ipcsem_pkg::*;

	localparam int OWN_W      = $clog2(NUM_CORES + 1);
	localparam int LINE_CORES = (NUM_CORES < LINE_W) ? NUM_CORES : LINE_W;

	logic [NUM_LEVELS-1:0]     int_raw_q  [NUM_CORES];
	logic [NUM_LEVELS-1:0]     int_mask_q [NUM_CORES];
	logic [NUM_SEMAPHORES-1:0] sem_raw_q  [NUM_CORES];
	logic [NUM_SEMAPHORES-1:0] sem_mask_q [NUM_CORES];
	logic [OWN_W-1:0]          owner_q    [NUM_SEMAPHORES];

	logic [NUM_LEVELS-1:0]     int_raw_n  [NUM_CORES];
	logic [NUM_LEVELS-1:0]     int_mask_n [NUM_CORES];
	logic [NUM_SEMAPHORES-1:0] sem_raw_n  [NUM_CORES];
	logic [NUM_SEMAPHORES-1:0] sem_mask_n [NUM_CORES];
	logic [OWN_W-1:0]          owner_n    [NUM_SEMAPHORES];

	logic              core_ok;
	logic              sem_ok;
	logic              is_wr;
	logic [OWN_W-1:0]  own_cur;
	logic [OWN_W-1:0]  own_code;
	logic [DATA_W-1:0] rd;
	logic              err;

	assign core_ok  = {30'd0, req.core_index} < 32'(NUM_CORES);
	assign sem_ok   = {27'd0, req.sem_index} < 32'(NUM_SEMAPHORES);
	assign is_wr    = (req.command == CMD_WRITE);
	assign own_code = OWN_W'(req.core_index) + OWN_W'(1);

	always_comb begin
		own_cur = '0;
		for (int s = 0; s < NUM_SEMAPHORES; s++) begin
			if (req.sem_index == SEM_W'(s))
				own_cur = owner_q[s];
		end
	end

	always_comb begin
		int_raw_n  = int_raw_q;
		int_mask_n = int_mask_q;
		sem_raw_n  = sem_raw_q;
		sem_mask_n = sem_mask_q;
		owner_n    = owner_q;
		rd  = '0;
		err = !core_ok;
		for (int c = 0; c < NUM_CORES; c++) begin
			if ({30'd0, req.core_index} == 32'(c)) begin
				case (req.reg_select)
					REG_RAW: begin
						if (is_wr)
							int_raw_n[c] = int_raw_q[c] | req.write_data[NUM_LEVELS-1:0];
						else
							rd = 32'(int_raw_q[c]);
					end
					REG_MASK: begin
						if (is_wr)
							int_mask_n[c] = req.write_data[NUM_LEVELS-1:0];
						else
							rd = 32'(int_mask_q[c]);
					end
					REG_STAT: begin
						if (is_wr)
							err = 1'b1;
						else
							rd = 32'(int_raw_q[c] & int_mask_q[c]);
					end
					REG_CLEAR: begin
						if (is_wr)
							int_raw_n[c] = int_raw_q[c] & ~req.write_data[NUM_LEVELS-1:0];
						else
							err = 1'b1;
					end
					REG_SEM_MASK: begin
						if (is_wr)
							sem_mask_n[c] = req.write_data[NUM_SEMAPHORES-1:0];
						else
							rd = 32'(sem_mask_q[c]);
					end
					REG_SEM_STAT: begin
						if (is_wr)
							err = 1'b1;
						else
							rd = 32'(sem_raw_q[c] & sem_mask_q[c]);
					end
					REG_SEM_CLEAR: begin
						if (is_wr)
							sem_raw_n[c] = sem_raw_q[c] & ~req.write_data[NUM_SEMAPHORES-1:0];
						else
							err = 1'b1;
					end
					default: begin
					end
				endcase
			end
		end
		// handshake: grant on read of a free semaphore, release on owner write of zero
		if (core_ok && req.reg_select == REG_HANDSHAKE) begin
			if (!sem_ok) begin
				err = 1'b1;
			end else if (!is_wr) begin
				if (own_cur == '0) begin
					for (int s = 0; s < NUM_SEMAPHORES; s++) begin
						if (req.sem_index == SEM_W'(s))
							owner_n[s] = own_code;
					end
				end else begin
					rd = 32'(own_cur);
				end
			end else if (req.write_data == '0 && own_cur == own_code) begin
				for (int s = 0; s < NUM_SEMAPHORES; s++) begin
					if (req.sem_index == SEM_W'(s))
						owner_n[s] = '0;
				end
				for (int c = 0; c < NUM_CORES; c++) begin
					if ({30'd0, req.core_index} != 32'(c))
						sem_raw_n[c] = sem_raw_q[c]
							| (NUM_SEMAPHORES'(1) << req.sem_index);
				end
			end
		end
	end

	always_comb begin
		rsp.read_data     = rd;
		rsp.access_error  = err;
		rsp.cpu_irq_lines = '0;
		rsp.sem_irq_lines = '0;
		for (int c = 0; c < LINE_CORES; c++) begin
			rsp.cpu_irq_lines[c] = |(int_raw_n[c] & int_mask_n[c]);
			rsp.sem_irq_lines[c] = |(sem_raw_n[c] & sem_mask_n[c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CORES; c++) begin
				int_raw_q[c]  <= '0;
				int_mask_q[c] <= '0;
				sem_raw_q[c]  <= '0;
				sem_mask_q[c] <= '0;
			end
			for (int s = 0; s < NUM_SEMAPHORES; s++)
				owner_q[s] <= '0;
		end else if (fire) begin
			int_raw_q  <= int_raw_n;
			int_mask_q <= int_mask_n;
			sem_raw_q  <= sem_raw_n;
			sem_mask_q <= sem_mask_n;
			owner_q    <= owner_n;
		end
	end

endmodule

[rtl/ipc_interrupt_and_hw_semaphore_top.sv]
// Inter-processor interrupt and hardware semaphore block. Each input word is one
// register access; it is captured in an input register, decoded combinationally
// against the banks and its response lands in an output register. One access per
// clock is sustained while the output register drains; the rate is held back only
// by the output register not draining (m_axis_tready).
// depends on ipcsem_pkg and ipcsem_bank
module ipc_interrupt_and_hw_semaphore_top #(
	parameter int NUM_CORES      = ipcsem_pkg::NUM_CORES_DEF,
	parameter int NUM_LEVELS     = ipcsem_pkg::NUM_LEVELS_DEF,
	parameter int NUM_SEMAPHORES = ipcsem_pkg::NUM_SEMAPHORES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// core_index, sem_index, write_data, zero pad
	input  logic [ipcsem_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// command, reg_select
	input  logic [ipcsem_pkg::S_TUSER_W-1:0] s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// read_data, cpu_irq_lines, sem_irq_lines
	output logic [ipcsem_pkg::M_TDATA_W-1:0] m_axis_tdata,
	// access_error
	output logic                             m_axis_tuser
);
	import ipcsem_pkg::*;

	logic valid_s1;
	req_t req_s1;
	logic m_valid_q;
	rsp_t rsp_q;
	rsp_t rsp;
	logic adv;
	logic fire;

	assign adv           = !m_valid_q || m_axis_tready;
	assign fire          = valid_s1 && adv;
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			req_s1.command    <= s_axis_tuser[0];
			req_s1.reg_select <= reg_sel_t'(s_axis_tuser[3:1]);
			req_s1.core_index <= s_axis_tdata[1:0];
			req_s1.sem_index  <= s_axis_tdata[6:2];
			req_s1.write_data <= s_axis_tdata[38:7];
		end
	end

	ipcsem_bank #(
		.NUM_CORES      (NUM_CORES),
		.NUM_LEVELS     (NUM_LEVELS),
		.NUM_SEMAPHORES (NUM_SEMAPHORES)
	) u_bank (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.req    (req_s1),
		.rsp    (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire)
			rsp_q <= rsp;
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {rsp_q.sem_irq_lines, rsp_q.cpu_irq_lines, rsp_q.read_data};
	assign m_axis_tuser  = rsp_q.access_error;

endmodule

[tb/ipc_interrupt_and_hw_semaphore_top_tb.sv]
// self-checking testbench for the inter-processor interrupt and semaphore block
// drives register accesses on the input stream and checks every response word
// against its own model of the banks; depends on ipcsem_pkg and the block's rtl
module ipc_interrupt_and_hw_semaphore_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ipcsem_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	// core_index, sem_index, write_data, zero pad
	logic [S_TDATA_W-1:0] s_axis_tdata;
	// command, reg_select
	logic [S_TUSER_W-1:0] s_axis_tuser;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	// read_data, cpu_irq_lines, sem_irq_lines
	logic [M_TDATA_W-1:0] m_axis_tdata;
	// access_error
	logic                 m_axis_tuser;

	ipc_interrupt_and_hw_semaphore_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	logic [DATA_W-1:0] int_raw  [NUM_CORES_DEF];
	logic [DATA_W-1:0] int_mask [NUM_CORES_DEF];
	logic [DATA_W-1:0] sem_raw  [NUM_CORES_DEF];
	logic [DATA_W-1:0] sem_mask [NUM_CORES_DEF];
	logic [2:0]        sem_owner[NUM_SEMAPHORES_DEF];

	rsp_t pending_responses[$];
	int   send_idle_pct;
	int   recv_idle_pct;
	int   recv_hold_cycles;
	int   mismatches;
	int   cycles;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("ipc_interrupt_and_hw_semaphore_top verification failed");
			$finish;
		end
	end

	// receiver: random stalls plus a long hold-off on request
	always @(negedge clk) begin
		if (recv_hold_cycles > 0) begin
			m_axis_tready = 1'b0;
			recv_hold_cycles--;
		end else begin
			m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic rsp_t bank_response(input req_t acc);
		rsp_t       rsp;
		logic       wr;
		int         c;
		int         s;
		logic [2:0] me;
		rsp = '0;
		wr = (acc.command == CMD_WRITE);
		c = acc.core_index;
		s = acc.sem_index;
		me = 3'(c + 1);
		if (c >= NUM_CORES_DEF) begin
			rsp.access_error = 1'b1;
		end else begin
			case (acc.reg_select)
				REG_RAW: begin
					if (wr) int_raw[c] |= acc.write_data;
					else rsp.read_data = int_raw[c];
				end
				REG_MASK: begin
					if (wr) int_mask[c] = acc.write_data;
					else rsp.read_data = int_mask[c];
				end
				REG_STAT: begin
					if (wr) rsp.access_error = 1'b1;
					else rsp.read_data = int_raw[c] & int_mask[c];
				end
				REG_CLEAR: begin
					if (wr) int_raw[c] &= ~acc.write_data;
					else rsp.access_error = 1'b1;
				end
				REG_SEM_MASK: begin
					if (wr) sem_mask[c] = acc.write_data;
					else rsp.read_data = sem_mask[c];
				end
				REG_SEM_STAT: begin
					if (wr) rsp.access_error = 1'b1;
					else rsp.read_data = sem_raw[c] & sem_mask[c];
				end
				REG_SEM_CLEAR: begin
					if (wr) sem_raw[c] &= ~acc.write_data;
					else rsp.access_error = 1'b1;
				end
				REG_HANDSHAKE: begin
					if (s >= NUM_SEMAPHORES_DEF) begin
						rsp.access_error = 1'b1;
					end else if (!wr) begin
						if (sem_owner[s] == 3'd0) sem_owner[s] = me;
						else rsp.read_data = DATA_W'(sem_owner[s]);
					end else if (acc.write_data == '0 && sem_owner[s] == me) begin
						sem_owner[s] = 3'd0;
						for (int k = 0; k < NUM_CORES_DEF; k++)
							if (k != c) sem_raw[k][s] = 1'b1;
					end
				end
				default: ;
			endcase
		end
		for (int k = 0; k < LINE_W; k++) begin
			rsp.cpu_irq_lines[k] = |(int_raw[k] & int_mask[k]);
			rsp.sem_irq_lines[k] = |(sem_raw[k] & sem_mask[k]);
		end
		return rsp;
	endfunction

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_responses.size() == 0) begin
				$error("response word with none expected: tdata %h tuser %b",
					m_axis_tdata, m_axis_tuser);
				mismatches++;
			end else begin
				want = pending_responses.pop_front();
				if (m_axis_tdata[31:0] !== want.read_data) begin
					$error("read_data expected %h got %h", want.read_data, m_axis_tdata[31:0]);
					mismatches++;
				end
				if (m_axis_tdata[35:32] !== want.cpu_irq_lines) begin
					$error("cpu_irq_lines expected %h got %h",
						want.cpu_irq_lines, m_axis_tdata[35:32]);
					mismatches++;
				end
				if (m_axis_tdata[39:36] !== want.sem_irq_lines) begin
					$error("sem_irq_lines expected %h got %h",
						want.sem_irq_lines, m_axis_tdata[39:36]);
					mismatches++;
				end
				if (m_axis_tuser !== want.access_error) begin
					$error("access_error expected %b got %b", want.access_error, m_axis_tuser);
					mismatches++;
				end
			end
		end
	end

	task automatic send_access(input logic cmd, input reg_sel_t sel, input int core,
		input int sem, input logic [DATA_W-1:0] data);
		req_t acc;
		acc.command = cmd;
		acc.reg_select = sel;
		acc.core_index = CORE_W'(core);
		acc.sem_index = SEM_W'(sem);
		acc.write_data = data;
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tdata = {1'b0, acc.write_data, acc.sem_index, acc.core_index};
		s_axis_tuser = {acc.reg_select, acc.command};
		s_axis_tvalid = 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pending_responses.push_back(bank_response(acc));
		@(negedge clk);
	endtask

	function automatic logic [DATA_W-1:0] random_word();
		int pick;
		pick = $urandom_range(9);
		if (pick < 4) return $urandom;
		if (pick < 6) return DATA_W'(1) << $urandom_range(31);
		if (pick == 6) return '1;
		if (pick == 7) return '0;
		return $urandom & $urandom;
	endfunction

	task automatic check_irq_registers();
		send_access(CMD_WRITE, REG_RAW, 0, 0, '1);
		send_access(CMD_READ, REG_STAT, 0, 0, '0);
		send_access(CMD_WRITE, REG_MASK, 0, 0, '1);
		send_access(CMD_READ, REG_STAT, 0, 0, '0);
		send_access(CMD_WRITE, REG_CLEAR, 0, 0, 32'h0000_FFFF);
		send_access(CMD_READ, REG_RAW, 0, 0, '0);
		send_access(CMD_WRITE, REG_STAT, 0, 0, '1);
		send_access(CMD_READ, REG_CLEAR, 0, 0, '0);
		send_access(CMD_WRITE, REG_RAW, 3, 31, 32'h8000_0000);
		send_access(CMD_WRITE, REG_MASK, 3, 31, 32'h8000_0000);
		send_access(CMD_READ, REG_MASK, 3, 31, '0);
		send_access(CMD_WRITE, REG_CLEAR, 3, 31, '1);
	endtask

	task automatic check_semaphore_handshake();
		send_access(CMD_READ, REG_HANDSHAKE, 1, 0, '0);
		send_access(CMD_READ, REG_HANDSHAKE, 2, 0, '0);
		send_access(CMD_READ, REG_HANDSHAKE, 1, 0, '0);
		send_access(CMD_WRITE, REG_HANDSHAKE, 1, 0, 32'h1);
		send_access(CMD_WRITE, REG_HANDSHAKE, 2, 0, '0);
		send_access(CMD_WRITE, REG_SEM_MASK, 2, 0, '1);
		send_access(CMD_WRITE, REG_HANDSHAKE, 1, 0, '0);
		send_access(CMD_WRITE, REG_HANDSHAKE, 1, 0, '0);
		send_access(CMD_READ, REG_SEM_STAT, 2, 0, '0);
		send_access(CMD_WRITE, REG_SEM_STAT, 2, 0, '1);
		send_access(CMD_READ, REG_SEM_CLEAR, 2, 0, '0);
		send_access(CMD_WRITE, REG_SEM_CLEAR, 2, 0, '1);
		send_access(CMD_READ, REG_HANDSHAKE, 3, 31, '0);
		send_access(CMD_WRITE, REG_HANDSHAKE, 3, 31, '0);
	endtask

	// over half the traffic is handshake accesses, mostly on a few semaphores, releases mostly by the owner
	task automatic run_random_traffic(input int words, input int in_pct, input int out_pct);
		logic     cmd;
		reg_sel_t sel;
		int       core;
		int       sem;
		logic [DATA_W-1:0] data;
		send_idle_pct = in_pct;
		recv_idle_pct = out_pct;
		repeat (words) begin
			cmd = 1'($urandom_range(1));
			sel = reg_sel_t'($urandom_range(7));
			if ($urandom_range(1) == 1) sel = REG_HANDSHAKE;
			core = $urandom_range(NUM_CORES_DEF - 1);
			sem = ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(3);
			data = random_word();
			if (sel == REG_HANDSHAKE && cmd == CMD_WRITE) begin
				if ($urandom_range(3) != 0) data = '0;
				if (sem_owner[sem] != 3'd0 && $urandom_range(9) < 7) core = sem_owner[sem] - 1;
			end
			send_access(cmd, sel, core, sem, data);
		end
	endtask

	task automatic check_input_stall();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		recv_hold_cycles = 300;
		repeat (30)
			send_access(1'($urandom_range(1)), reg_sel_t'($urandom_range(7)),
				$urandom_range(3), $urandom_range(31), random_word());
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		recv_hold_cycles = 0;
		mismatches = 0;
		cycles = 0;
		for (int k = 0; k < NUM_CORES_DEF; k++) begin
			int_raw[k] = '0;
			int_mask[k] = '0;
			sem_raw[k] = '0;
			sem_mask[k] = '0;
		end
		for (int k = 0; k < NUM_SEMAPHORES_DEF; k++) sem_owner[k] = 3'd0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		check_irq_registers();
		check_semaphore_handshake();
		run_random_traffic(350, 29, 63);
		run_random_traffic(350, 63, 29);
		check_input_stall();
		run_random_traffic(350, 0, 0);
		s_axis_tvalid = 1'b0;

		while (pending_responses.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatches == 0) begin
			$display("ipc_interrupt_and_hw_semaphore_top verification clean");
		end else begin
			$display("ipc_interrupt_and_hw_semaphore_top verification failed");
		end
		$finish;
	end

endmodule
